FILE: sv/hdt_pkg.sv
// ----------------------------------------------------------------------------
// hdt_pkg
// Shared constants and controller/datapath interface types for the Hall
// direction tachometer.
// ----------------------------------------------------------------------------
package hdt_pkg;

  // timestamp state width; the port timestamp is always 32 bits
  localparam int unsigned TIME_BITS = 32;

  localparam int unsigned PPR_W  = 10;
  localparam int unsigned MAG_W  = 24;
  localparam int unsigned RPM_W  = MAG_W + 1;
  localparam int unsigned DEN_W  = MAG_W + PPR_W;
  localparam int unsigned CNT_W  = $clog2(MAG_W);

  localparam logic [PPR_W-1:0] PPR_RESET  = PPR_W'(90);
  // 60000 rpm*ms scaled by 256 for Q16.8
  localparam logic [MAG_W-1:0] RPM_NUM_Q8 = MAG_W'(15360000);
  localparam logic [MAG_W-1:0] RPM_SAT    = {MAG_W{1'b1}};
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(MAG_W - 1);

  // sensor codes
  localparam logic [1:0] SENSOR_U   = 2'd0;
  localparam logic [1:0] SENSOR_V   = 2'd1;
  localparam logic [1:0] SENSOR_W   = 2'd2;
  localparam logic [1:0] SENSOR_BAD = 2'd3;

  typedef struct packed {
    logic load;      // capture request, update counters
    logic mul;       // form divisor
    logic step;      // one restoring division step
    logic out_load;  // move result into output register
  } hdt_cmd_t;

  typedef struct packed {
    logic div_last;
  } hdt_status_t;

endpackage

FILE: sv/hdt_ctrl.sv
// ----------------------------------------------------------------------------
// hdt_ctrl
// Sequencer: accept, multiply, iterate the divider, hand off the result.
// ----------------------------------------------------------------------------
module hdt_ctrl
  import hdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic [1:0]  s_sensor_i,
  output logic        s_ready_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output hdt_cmd_t    cmd_o,
  input  hdt_status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    s_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        // code 3 is accepted and dropped
        if (s_valid_i && s_sensor_i != SENSOR_BAD) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.out_load) m_valid_d = 1'b1;
    else if (m_ready_i) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

FILE: sv/hdt_datapath.sv
// ----------------------------------------------------------------------------
// hdt_datapath
// Direction, pulse count, period, divisor multiply, bit-serial divider and
// output register.
// ----------------------------------------------------------------------------
module hdt_datapath
  import hdt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PPR_W-1:0]  cfg_wdata_i,
  input  logic [1:0]        sensor_i,
  input  logic              level_u_i,
  input  logic              level_v_i,
  input  logic              level_w_i,
  input  logic [31:0]       time_ms_i,
  input  hdt_cmd_t          cmd_i,
  output hdt_status_t       status_o,
  output logic              direction_ccw_o,
  output logic [31:0]       pulse_total_o,
  output logic [31:0]       period_ms_o,
  output logic [RPM_W-1:0]  rpm_q8_o,
  output logic              speed_saturated_o
);

  logic [PPR_W-1:0]     ppr_q;
  logic [31:0]          accum_q, accum_d;
  logic [TIME_BITS-1:0] last_q, now, period;
  logic                 ccw_q, ccw_d;
  logic [TIME_BITS-1:0] period_q;
  logic                 sat_q, long_q;
  logic [DEN_W-1:0]     den_q;
  logic [MAG_W-1:0]     num_q, rem_q, quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [MAG_W:0]       trial;
  logic                 fits;
  logic [MAG_W-1:0]     mag;

  always_comb begin
    case (sensor_i)
      SENSOR_U: ccw_d = level_u_i ^ level_w_i;
      SENSOR_V: ccw_d = level_v_i ^ level_u_i;
      SENSOR_W: ccw_d = level_w_i ^ level_v_i;
      default:  ccw_d = 1'b0;
    endcase
    accum_d = ccw_d ? accum_q - 32'd1 : accum_q + 32'd1;
    now     = TIME_BITS'(time_ms_i);
    period  = now - last_q;
  end

  // restoring division step; remainder always stays below 2^MAG_W
  assign trial = {rem_q, num_q[MAG_W-1]};
  assign fits  = DEN_W'(trial) >= den_q;
  assign status_o.div_last = (cnt_q == DIV_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q   <= PPR_RESET;
      accum_q <= '0;
      last_q  <= '0;
    end else begin
      if (cfg_we_i) ppr_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        accum_q <= accum_d;
        last_q  <= now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ccw_q    <= ccw_d;
      period_q <= period;
      sat_q    <= (period == '0) || (ppr_q == '0);
      long_q   <= (period >> MAG_W) != '0;
    end
    if (cmd_i.mul) begin
      den_q <= DEN_W'(MAG_W'(period_q)) * DEN_W'(ppr_q);
      num_q <= RPM_NUM_Q8;
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.step) begin
      num_q <= {num_q[MAG_W-2:0], 1'b0};
      rem_q <= fits ? MAG_W'(trial - (MAG_W+1)'(den_q)) : MAG_W'(trial);
      quo_q <= {quo_q[MAG_W-2:0], fits};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.out_load) begin
      direction_ccw_o   <= ccw_q;
      pulse_total_o     <= accum_q;
      period_ms_o       <= 32'(period_q);
      rpm_q8_o          <= ccw_q ? RPM_W'(0) - {1'b0, mag} : {1'b0, mag};
      speed_saturated_o <= sat_q;
    end
  end

  assign mag = sat_q ? RPM_SAT : (long_q ? '0 : quo_q);

endmodule

FILE: sv/hall_direction_tachometer.sv
// ----------------------------------------------------------------------------
// hall_direction_tachometer
// Hall edge direction decode, pulse counter and rpm estimate in Q16.8.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                 payload
//  s_axis   in   tvalid/tready             tdata levels+time, tuser sensor
//  m_axis   out  tvalid/tready             tdata dir/count/period/rpm, tuser sat
//  cfg      in   cfg_we_i                  cfg_wdata_i = pulses_per_rev
//
//  A request is captured at its accepting edge; the result is formed by the
//  period * pulses_per_rev multiply and the restoring divider, then loaded
//  into the output register. A new request is taken only after that load.
//  Reset clears pulse count and last timestamp, pulses_per_rev goes to 90.
//  A result waiting on m_axis does not block the next request; the block
//  holds in its final step only if the output register is still full.
//  Sensor code 3 is accepted and dropped without a result.
// ----------------------------------------------------------------------------
module hall_direction_tachometer
  import hdt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PPR_W-1:0]  cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [0] level_u, [1] level_v, [2] level_w, [34:3] time_ms, rest zero
  input  logic [39:0]       s_axis_tdata_i,
  // [1:0] edge_sensor
  input  logic [1:0]        s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [0] direction_ccw, [32:1] pulse_total, [64:33] period_ms,
  // [89:65] rpm_q8, rest zero
  output logic [95:0]       m_axis_tdata_o,
  // [0] speed_saturated
  output logic              m_axis_tuser_o
);

  hdt_cmd_t         cmd;
  hdt_status_t      status;
  logic             dir_ccw;
  logic [31:0]      pulse_total;
  logic [31:0]      period_ms;
  logic [RPM_W-1:0] rpm_q8;

  hdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_sensor_i (s_axis_tuser_i),
    .s_ready_o  (s_axis_tready_o),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  hdt_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .sensor_i          (s_axis_tuser_i),
    .level_u_i         (s_axis_tdata_i[0]),
    .level_v_i         (s_axis_tdata_i[1]),
    .level_w_i         (s_axis_tdata_i[2]),
    .time_ms_i         (s_axis_tdata_i[34:3]),
    .cmd_i             (cmd),
    .status_o          (status),
    .direction_ccw_o   (dir_ccw),
    .pulse_total_o     (pulse_total),
    .period_ms_o       (period_ms),
    .rpm_q8_o          (rpm_q8),
    .speed_saturated_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {6'd0, rpm_q8, period_ms, pulse_total, dir_ccw};

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Hall direction tachometer. Edge requests go in
// on s_axis; each reading on m_axis is checked against a typed table row or an
// in-bench model of the direction decode, pulse counter, period and Q16.8 rpm
// math. Runs a short directed table, then random edges over several settings
// of pulses-per-rev, sender bursts/gaps, stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import hdt_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned WATCHDOG_CYCLES  = 2000;
  localparam int unsigned PHASES           = 7;
  localparam int unsigned EDGES_PER_PHASE  = 100;
  localparam int unsigned DIRECTED_ROWS    = 16;

  typedef struct packed {
    logic [1:0]  sensor;
    logic        lu;
    logic        lv;
    logic        lw;
    logic [31:0] stamp;
  } hall_event_t;

  typedef struct packed {
    logic        ccw;
    logic [31:0] total;
    logic [31:0] period;
    logic [24:0] rpm;
    logic        sat;
  } tach_reading_t;

  // typed = 1: the want_* fields are the expected reading
  typedef struct packed {
    logic [1:0]  sensor;
    logic        lu;
    logic        lv;
    logic        lw;
    logic [31:0] stamp;
    logic        typed;
    logic        want_ccw;
    logic [31:0] want_total;
    logic [31:0] want_period;
    logic [24:0] want_rpm;
    logic        want_sat;
  } edge_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [PPR_W-1:0]  cfg_wdata_i = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [39:0]       s_axis_tdata_i = '0;
  logic [1:0]        s_axis_tuser_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [95:0]       m_axis_tdata_o;
  logic              m_axis_tuser_o;

  // in-bench copy of the block state
  logic [31:0]       pulse_count;
  logic [31:0]       last_stamp;
  logic [PPR_W-1:0]  ppr_setting;

  tach_reading_t     pending_readings[$];
  logic [31:0]       stamp_cursor = '0;
  int unsigned       burst_left = 0;
  bit                idling_on = 1'b1;
  bit                hold_off_req = 1'b0;
  int unsigned       mismatches = 0;
  int unsigned       readings_checked = 0;
  int unsigned       edges_sent = 0;
  int unsigned       dropped_codes = 0;
  int unsigned       saturated_seen = 0;
  int unsigned       settings_used = 1;
  int unsigned       quiet_cycles = 0;

  edge_row_t directed_rows [DIRECTED_ROWS] = '{
    '{SENSOR_U, 1'b0, 1'b0, 1'b0, 32'd0,
      1'b1, 1'b0, 32'd1, 32'd0, 25'h0FFFFFF, 1'b1},
    '{SENSOR_V, 1'b1, 1'b0, 1'b0, 32'd0,
      1'b1, 1'b1, 32'd0, 32'd0, 25'h1000001, 1'b1},
    '{SENSOR_W, 1'b0, 1'b0, 1'b1, 32'd1000,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    '{SENSOR_BAD, 1'b1, 1'b1, 1'b1, 32'hFFFFFFFF,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    // period of exactly 2^24 ms reads as standstill
    '{SENSOR_U, 1'b1, 1'b0, 1'b1, 32'd16778216,
      1'b1, 1'b0, 32'd0, 32'h01000000, 25'd0, 1'b0},
    '{SENSOR_V, 1'b0, 1'b0, 1'b1, 32'd33555431,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    '{SENSOR_W, 1'b1, 1'b1, 1'b0, 32'd33555432,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    '{SENSOR_U, 1'b1, 1'b1, 1'b0, 32'hFFFFFFFF,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    // timestamp wraps around
    '{SENSOR_V, 1'b0, 1'b1, 1'b1, 32'h00000001,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    '{SENSOR_W, 1'b1, 1'b0, 1'b0, 32'h00000001,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    '{SENSOR_U, 1'b0, 1'b1, 1'b1, 32'h80000001,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    '{SENSOR_V, 1'b1, 1'b1, 1'b0, 32'h80000002,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    '{SENSOR_W, 1'b0, 1'b1, 1'b1, 32'h7FFFFFFF,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    '{SENSOR_BAD, 1'b0, 1'b0, 1'b0, 32'd0,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    '{SENSOR_U, 1'b1, 1'b1, 1'b1, 32'hAAAAAAAA,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0},
    '{SENSOR_V, 1'b0, 1'b0, 1'b0, 32'h55555555,
      1'b0, 1'b0, 32'd0, 32'd0, 25'd0, 1'b0}
  };

  hall_direction_tachometer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Direction, pulse count, period and rpm for one edge; updates the state.
  // Returns 0 for the invalid sensor code, which leaves the state alone.
  function automatic bit tach_edge(input hall_event_t ev, output tach_reading_t rd);
    logic        own;
    logic        partner;
    logic [31:0] span;
    logic [23:0] mag;
    logic [63:0] den;
    rd = '0;
    case (ev.sensor)
      SENSOR_U: begin
        own = ev.lu;
        partner = ev.lw;
      end
      SENSOR_V: begin
        own = ev.lv;
        partner = ev.lu;
      end
      SENSOR_W: begin
        own = ev.lw;
        partner = ev.lv;
      end
      default: return 1'b0;
    endcase
    rd.ccw = (own != partner);
    pulse_count = rd.ccw ? pulse_count - 32'd1 : pulse_count + 32'd1;
    rd.total = pulse_count;
    span = ev.stamp - last_stamp;
    last_stamp = ev.stamp;
    rd.period = span;
    if (span == '0 || ppr_setting == '0) begin
      mag = RPM_SAT;
      rd.sat = 1'b1;
    end else if (span >= 32'h01000000) begin
      mag = '0;
    end else begin
      den = 64'(span) * 64'(ppr_setting);
      mag = 24'(64'(RPM_NUM_Q8) / den);
    end
    rd.rpm = {1'b0, mag};
    if (rd.ccw) rd.rpm = -rd.rpm;
    return 1'b1;
  endfunction

  // Mostly short periods so the divider sees real values, some zero periods,
  // some near and past the 2^24 ms standstill limit, some random jumps.
  function automatic hall_event_t next_random_event();
    hall_event_t ev;
    int unsigned pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0, 1:          stamp_cursor = stamp_cursor;
      2, 3, 4, 5:    stamp_cursor = stamp_cursor + $urandom_range(1, 16);
      6, 7, 8, 9:    stamp_cursor = stamp_cursor + $urandom_range(17, 5000);
      10, 11:        stamp_cursor = stamp_cursor + $urandom_range(1, 200);
      12:            stamp_cursor = stamp_cursor + $urandom_range(5001, 32'h01000100);
      13:            stamp_cursor = stamp_cursor + $urandom;
      default:       stamp_cursor = stamp_cursor + $urandom_range(1, 400000);
    endcase
    if ($urandom_range(0, 31) == 0) stamp_cursor = $urandom;
    ev.stamp = stamp_cursor;
    ev.sensor = ($urandom_range(0, 15) == 0) ? SENSOR_BAD : 2'($urandom_range(0, 2));
    ev.lu = 1'($urandom);
    ev.lv = 1'($urandom);
    ev.lw = 1'($urandom);
    return ev;
  endfunction

  // Offers one edge request, waits for it to be taken, queues the reading.
  task automatic send_edge(input hall_event_t ev, input bit typed, input tach_reading_t want);
    tach_reading_t rd;
    int unsigned   gap;
    if (idling_on) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 45) : $urandom_range(0, 12);
        burst_left = $urandom_range(1, 16);
        if (gap != 0) begin
          s_axis_tvalid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {5'b0, ev.stamp, ev.lw, ev.lv, ev.lu};
    s_axis_tuser_i <= ev.sensor;
    do @(posedge clk_i); while (!s_axis_tready_o);
    edges_sent++;
    if (tach_edge(ev, rd)) pending_readings.push_back(typed ? want : rd);
    else dropped_codes++;
  endtask

  // Register writes only with the block idle; a dropped code never enters the
  // divider, so draining the queued readings suffices; the extra pause is margin.
  task automatic write_ppr(input logic [PPR_W-1:0] value);
    s_axis_tvalid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ppr_setting = value;
    settings_used++;
  endtask

  task automatic check_reading(input logic [95:0] data, input logic sat_flag);
    tach_reading_t seen;
    tach_reading_t want;
    seen.ccw = data[0];
    seen.total = data[32:1];
    seen.period = data[64:33];
    seen.rpm = data[89:65];
    seen.sat = sat_flag;
    if (pending_readings.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected reading: tdata=%h tuser=%b", data, sat_flag);
    end else begin
      want = pending_readings.pop_front();
      readings_checked++;
      if (seen.sat) saturated_seen++;
      if (seen.ccw !== want.ccw || seen.total !== want.total || seen.period !== want.period
          || seen.rpm !== want.rpm || seen.sat !== want.sat) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("reading %0d mismatch: expected ccw=%b total=%0d period=%0d rpm=%0d sat=%b",
                   readings_checked, want.ccw, $signed(want.total), want.period,
                   $signed(want.rpm), want.sat);
          $display("                      actual   ccw=%b total=%0d period=%0d rpm=%0d sat=%b",
                   seen.ccw, $signed(seen.total), seen.period, $signed(seen.rpm), seen.sat);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_reading(m_axis_tdata_o, m_axis_tuser_o);
  end

  // receiver: ready/stall runs of random length, always ready in the flat-out phase, plus the long hold-off
  initial begin
    int unsigned run_left;
    logic        ready_state;
    run_left = 0;
    ready_state = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (!idling_on) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        if (run_left == 0) begin
          ready_state = !ready_state;
          run_left = ready_state ? $urandom_range(1, 20) : $urandom_range(1, 8);
        end
        run_left--;
        m_axis_tready_i <= ready_state;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_CYCLES);
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    logic [PPR_W-1:0] ppr_plan [PHASES];
    hall_event_t      ev;
    tach_reading_t    want;
    int unsigned      valid_sent;
    pulse_count = '0;
    last_stamp = '0;
    ppr_setting = PPR_RESET;
    ppr_plan[0] = 10'd1;
    ppr_plan[1] = 10'd1023;
    ppr_plan[2] = 10'd0;
    ppr_plan[3] = 10'($urandom_range(2, 1022));
    ppr_plan[4] = 10'd512;
    ppr_plan[5] = 10'($urandom_range(1, 1023));
    ppr_plan[6] = PPR_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[r]) begin
      ev = {directed_rows[r].sensor, directed_rows[r].lu, directed_rows[r].lv,
            directed_rows[r].lw, directed_rows[r].stamp};
      want = {directed_rows[r].want_ccw, directed_rows[r].want_total,
              directed_rows[r].want_period, directed_rows[r].want_rpm,
              directed_rows[r].want_sat};
      send_edge(ev, directed_rows[r].typed, want);
    end
    stamp_cursor = directed_rows[DIRECTED_ROWS-1].stamp;

    for (int p = 0; p < PHASES; p++) begin
      write_ppr(ppr_plan[p]);
      // one phase runs flat out on both sides, one gets the long hold-off
      idling_on = (p != 1);
      if (p == 3) hold_off_req = 1'b1;
      valid_sent = 0;
      while (valid_sent < EDGES_PER_PHASE) begin
        ev = next_random_event();
        send_edge(ev, 1'b0, '0);
        if (ev.sensor != SENSOR_BAD) valid_sent++;
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d edge requests (%0d with the invalid sensor code), %0d readings checked",
             edges_sent, dropped_codes, readings_checked);
    $display("%0d pulses-per-rev settings incl. 0, 1 and 1023; %0d saturated readings",
             settings_used, saturated_seen);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatching readings", mismatches);
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/hdt_pkg.sv
sv/hdt_ctrl.sv
sv/hdt_datapath.sv
sv/hall_direction_tachometer.sv
bench/testbench.sv
